/* src/ptc_pkg.sv */
// Shared constants, types and helpers for the pressure/temperature compensation pipeline.
package ptc_pkg;

    localparam int TFINE_OFFSET = 128000;
    localparam int PRESS_SCALE  = 3125;
    localparam int RAW_FULL     = 1048576;
    localparam int TEMP_LOW     = -4000;
    localparam int TEMP_HIGH    = 8500;
    localparam int PRESS_LOW    = 7680000;
    localparam int PRESS_HIGH   = 28160000;

    // number of one-bit steps in the divider
    localparam int DIV_STEPS = 64;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUS   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_TEMP = 2'd0;
    localparam logic [1:0] REG_PLOW = 2'd1;
    localparam logic [1:0] REG_PMID = 2'd2;
    localparam logic [1:0] REG_PTOP = 2'd3;

    // per-request sideband carried alongside the pressure datapath
    typedef struct packed {
        logic               berr;
        logic               t_bad;
        logic               dz;
        logic signed [23:0] centi;
    } side_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage

/* src/ptc_mul64.sv */
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 partial products.
module ptc_mul64 (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] lo_reg;
    logic [31:0] x1_reg;
    logic [31:0] x2_reg;
    logic [63:0] p_reg;
    logic [63:0] c1;
    logic [63:0] c2;
    logic [31:0] xs;

    assign c1 = 64'(a[31:0]) * 64'(b[63:32]);
    assign c2 = 64'(a[63:32]) * 64'(b[31:0]);
    assign xs = x1_reg + x2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            x1_reg <= c1[31:0];
            x2_reg <= c2[31:0];
            p_reg  <= lo_reg + {xs, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

/* src/ptc_front.sv */
// Front pipeline: raw reassembly, temperature compensation and divider operands.
module ptc_front
    import ptc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic         bus_error,
    input  logic [7:0]   press_msb,
    input  logic [7:0]   press_lsb,
    input  logic [7:0]   press_xlsb,
    input  logic [7:0]   temp_msb,
    input  logic [7:0]   temp_lsb,
    input  logic [7:0]   temp_xlsb,
    input  logic [47:0]  temp_trim,
    input  logic [63:0]  press_low,
    input  logic [63:0]  press_mid,
    output logic         out_valid,
    output logic [63:0]  num,
    output logic [63:0]  den,
    output side_t        side
);

    localparam int LAST = 14;

    logic [19:0] adc_t;
    logic [19:0] adc_p;
    logic [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;

    logic [LAST:1] vld_reg;
    logic [19:0] ap_reg [1:11];
    logic        be_reg [1:LAST];
    logic signed [23:0] ce_reg [6:LAST];
    logic        tb_reg [6:LAST];

    logic signed [18:0] x1_reg;
    logic signed [17:0] d_reg;
    logic signed [34:0] m1_reg;
    logic signed [35:0] dd_reg;
    logic signed [23:0] v1_reg;
    logic signed [23:0] q_reg;
    logic signed [23:0] v1b_reg;
    logic signed [39:0] m3_reg;
    logic [27:0] tf_reg;
    logic [63:0] a0_reg;
    logic [63:0] a5d9_reg;
    logic [63:0] a5d10_reg;
    logic [63:0] a2d9_reg;
    logic [63:0] a2d10_reg;
    logic [63:0] b11_reg;
    logic [63:0] a11_reg;
    logic [63:0] num12_reg;
    logic [63:0] den14_reg;

    logic signed [18:0] x1_next;
    logic signed [17:0] d_next;
    logic signed [31:0] t5;
    logic signed [23:0] centi;
    logic [63:0] aa;
    logic [63:0] ap5;
    logic [63:0] ap2;
    logic [63:0] b6;
    logic [63:0] a3;
    logic [63:0] b_next;
    logic [63:0] a_next;
    logic [63:0] num_next;
    logic [63:0] p1prod;
    logic [63:0] nprod;

    assign adc_t = {temp_msb, temp_lsb, temp_xlsb[7:4]};
    assign adc_p = {press_msb, press_lsb, press_xlsb[7:4]};
    assign t1 = temp_trim[15:0];
    assign t2 = $signed(temp_trim[31:16]);
    assign t3 = $signed(temp_trim[47:32]);

    assign x1_next = $signed({2'b00, adc_t[19:3]}) - $signed({2'b00, t1, 1'b0});
    assign d_next  = $signed({2'b00, adc_t[19:4]}) - $signed({2'b00, t1});

    assign t5 = $signed({{4{tf_reg[27]}}, tf_reg}) * 32'sd5 + 32'sd128;
    assign centi = t5[31:8];

    ptc_mul64 u_mul_aa (.clk(clk), .en(en), .a(a0_reg), .b(a0_reg), .p(aa));
    ptc_mul64 u_mul_a5 (.clk(clk), .en(en), .a(a0_reg), .b(sx16(press_mid[15:0])), .p(ap5));
    ptc_mul64 u_mul_a2 (.clk(clk), .en(en), .a(a0_reg), .b(sx16(press_low[31:16])), .p(ap2));
    ptc_mul64 u_mul_b6 (.clk(clk), .en(en), .a(aa), .b(sx16(press_mid[31:16])), .p(b6));
    ptc_mul64 u_mul_a3 (.clk(clk), .en(en), .a(aa), .b(sx16(press_low[47:32])), .p(a3));

    assign b_next = b6 + (a5d10_reg << 17) + (sx16(press_low[63:48]) << 35);
    assign a_next = {{8{a3[63]}}, a3[63:8]} + (a2d10_reg << 12);

    ptc_mul64 u_mul_p1 (
        .clk(clk), .en(en),
        .a(64'h0000_8000_0000_0000 + a11_reg),
        .b({48'd0, press_low[15:0]}),
        .p(p1prod)
    );

    assign num_next = ((64'(RAW_FULL) - {44'd0, ap_reg[11]}) << 31) - b11_reg;

    ptc_mul64 u_mul_n (
        .clk(clk), .en(en), .a(num12_reg), .b(64'(PRESS_SCALE)), .p(nprod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ap_reg[1] <= adc_p;
            for (int i = 2; i <= 11; i++)
            begin
                ap_reg[i] <= ap_reg[i-1];
            end
            be_reg[1] <= bus_error;
            for (int i = 2; i <= LAST; i++)
            begin
                be_reg[i] <= be_reg[i-1];
            end
            ce_reg[6] <= centi;
            tb_reg[6] <= (centi < TEMP_LOW) || (centi > TEMP_HIGH);
            for (int i = 7; i <= LAST; i++)
            begin
                ce_reg[i] <= ce_reg[i-1];
                tb_reg[i] <= tb_reg[i-1];
            end

            x1_reg    <= x1_next;
            d_reg     <= d_next;
            m1_reg    <= x1_reg * t2;
            dd_reg    <= d_reg * d_reg;
            v1_reg    <= m1_reg[34:11];
            q_reg     <= dd_reg[35:12];
            v1b_reg   <= v1_reg;
            m3_reg    <= q_reg * t3;
            tf_reg    <= {{4{v1b_reg[23]}}, v1b_reg} + {{2{m3_reg[39]}}, m3_reg[39:14]};
            a0_reg    <= {{36{tf_reg[27]}}, tf_reg} - 64'(TFINE_OFFSET);
            a5d9_reg  <= ap5;
            a5d10_reg <= a5d9_reg;
            a2d9_reg  <= ap2;
            a2d10_reg <= a2d9_reg;
            b11_reg   <= b_next;
            a11_reg   <= a_next;
            num12_reg <= num_next;
            den14_reg <= {{33{p1prod[63]}}, p1prod[63:33]};
        end
    end

    assign out_valid  = vld_reg[LAST];
    assign num        = nprod;
    assign den        = den14_reg;
    assign side.berr  = be_reg[LAST];
    assign side.t_bad = tb_reg[LAST];
    assign side.dz    = (den14_reg == 64'd0);
    assign side.centi = ce_reg[LAST];

endmodule

/* src/ptc_div64.sv */
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
module ptc_div64
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] num,
    input  logic [63:0] den,
    input  side_t       side_i,
    output logic        out_valid,
    output logic [63:0] quo,
    output side_t       side_o
);

    logic [63:0] rem_reg [0:DIV_STEPS-1];
    logic [63:0] md_reg  [0:DIV_STEPS-1];
    logic [63:0] quo_reg [0:DIV_STEPS];
    logic        neg_reg [0:DIV_STEPS];
    side_t       sd_reg  [0:DIV_STEPS+1];
    logic [DIV_STEPS+1:0] vld_reg;
    logic [63:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 64'd0;
            quo_reg[0] <= num[63] ? (64'd0 - num) : num;
            md_reg[0]  <= den[63] ? (64'd0 - den) : den;
            neg_reg[0] <= num[63] ^ den[63];
            sd_reg[0]  <= side_i;
            for (int i = 1; i <= DIV_STEPS + 1; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
            q_reg <= neg_reg[DIV_STEPS] ? (64'd0 - quo_reg[DIV_STEPS]) : quo_reg[DIV_STEPS];
        end
    end

    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_step
        logic [64:0] sh;
        logic [64:0] diff;
        logic        ge;

        // remainder stays below the divisor, so the shifted value fits 64 bits
        assign sh   = {1'b0, rem_reg[i-1][62:0], quo_reg[i-1][63]};
        assign diff = sh - {1'b0, md_reg[i-1]};
        assign ge   = !diff[64];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= {quo_reg[i-1][62:0], ge};
                neg_reg[i] <= neg_reg[i-1];
            end
        end

        if (i < DIV_STEPS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? diff[63:0] : sh[63:0];
                    md_reg[i]  <= md_reg[i-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS+1];
    assign quo       = q_reg;
    assign side_o    = sd_reg[DIV_STEPS+1];

endmodule

/* src/ptc_back.sv */
// Back pipeline: pressure post-correction, range check, saturation and result register.
module ptc_back
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [63:0]        quo,
    input  side_t              side_i,
    input  logic [63:0]        press_mid,
    input  logic [15:0]        press_top,
    output logic               out_valid,
    output logic signed [23:0] temperature_centi,
    output logic [31:0]        pressure_q24_8,
    output logic [1:0]         status
);

    localparam int LAST = 6;

    logic [LAST:1] vld_reg;
    side_t         sd_reg [1:5];
    logic [63:0]   p_reg  [1:4];
    logic [63:0]   hp_reg [1:2];
    logic [63:0]   b_reg  [3:4];
    logic [63:0]   ps_reg;
    logic signed [23:0] temp_reg;
    logic [31:0]   press_reg;
    logic [1:0]    status_reg;

    logic [63:0] hp;
    logic [63:0] h;
    logic [63:0] p8p;
    logic [63:0] hh;
    logic [63:0] sum;
    logic [63:0] ps_next;
    logic signed [63:0] ps_s;
    logic        p_bad;

    assign hp = {{13{quo[63]}}, quo[63:13]};

    ptc_mul64 u_mul_h  (.clk(clk), .en(en), .a(sx16(press_top)), .b(hp), .p(h));
    ptc_mul64 u_mul_p8 (.clk(clk), .en(en), .a(sx16(press_mid[63:48])), .b(quo), .p(p8p));
    ptc_mul64 u_mul_hh (.clk(clk), .en(en), .a(h), .b(hp_reg[2]), .p(hh));

    assign sum     = p_reg[4] + {{25{hh[63]}}, hh[63:25]} + b_reg[4];
    assign ps_next = {{8{sum[63]}}, sum[63:8]} + (sx16(press_mid[47:32]) << 4);

    // a zero divisor forces pressure to 0
    assign ps_s  = sd_reg[5].dz ? 64'sd0 : $signed(ps_reg);
    assign p_bad = (ps_s < 64'(PRESS_LOW)) || (ps_s > 64'(PRESS_HIGH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[1] <= side_i;
            for (int i = 2; i <= 5; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
            p_reg[1] <= quo;
            for (int i = 2; i <= 4; i++)
            begin
                p_reg[i] <= p_reg[i-1];
            end
            hp_reg[1] <= hp;
            hp_reg[2] <= hp_reg[1];
            b_reg[3]  <= {{19{p8p[63]}}, p8p[63:19]};
            b_reg[4]  <= b_reg[3];
            ps_reg    <= ps_next;

            if (sd_reg[5].berr)
            begin
                temp_reg   <= '0;
                press_reg  <= '0;
                status_reg <= ST_BUS;
            end
            else
            begin
                temp_reg <= sd_reg[5].centi;
                if (ps_s < 64'sd0)
                    press_reg <= '0;
                else if (ps_s > 64'sh0000_0000_FFFF_FFFF)
                    press_reg <= 32'hFFFF_FFFF;
                else
                    press_reg <= ps_s[31:0];
                status_reg <= (sd_reg[5].t_bad || p_bad) ? ST_RANGE : ST_OK;
            end
        end
    end

    assign out_valid         = vld_reg[LAST];
    assign temperature_centi = temp_reg;
    assign pressure_q24_8    = press_reg;
    assign status            = status_reg;

endmodule

/* src/pressure_temperature_compensation_unit.sv */
// Top level: trim registers, pipeline enable and the three pipeline sections.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  in       | in_valid / in_stall    | bus_error, press_*, temp_* raw bytes
//  out      | out_valid / out_stall  | temperature_centi, pressure_q24_8, status
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// One request enters per cycle unless the pipeline is frozen; each passes the front,
// divider and back sections in turn, the divider's one-bit-per-stage chain setting the depth.
// The whole pipeline advances together; it freezes only while a result sits
// in the output register and out_stall is high, and in_stall mirrors that.
// Reset clears the valid bits and the trim registers; no clearing pass.
module pressure_temperature_compensation_unit
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               bus_error,
    input  logic [7:0]         press_msb,
    input  logic [7:0]         press_lsb,
    input  logic [7:0]         press_xlsb,
    input  logic [7:0]         temp_msb,
    input  logic [7:0]         temp_lsb,
    input  logic [7:0]         temp_xlsb,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] temperature_centi,
    output logic [31:0]        pressure_q24_8,
    output logic [1:0]         status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    logic [47:0] temp_trim_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_mid_reg;
    logic [15:0] press_top_reg;

    logic        en;
    logic        f_valid;
    logic [63:0] f_num;
    logic [63:0] f_den;
    side_t       f_side;
    logic        d_valid;
    logic [63:0] d_quo;
    side_t       d_side;

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg <= '0;
            press_low_reg <= '0;
            press_mid_reg <= '0;
            press_top_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP: temp_trim_reg <= cfg_data[47:0];
                REG_PLOW: press_low_reg <= cfg_data;
                REG_PMID: press_mid_reg <= cfg_data;
                REG_PTOP: press_top_reg <= cfg_data[15:0];
            endcase
        end
    end

    ptc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .bus_error  (bus_error),
        .press_msb  (press_msb),
        .press_lsb  (press_lsb),
        .press_xlsb (press_xlsb),
        .temp_msb   (temp_msb),
        .temp_lsb   (temp_lsb),
        .temp_xlsb  (temp_xlsb),
        .temp_trim  (temp_trim_reg),
        .press_low  (press_low_reg),
        .press_mid  (press_mid_reg),
        .out_valid  (f_valid),
        .num        (f_num),
        .den        (f_den),
        .side       (f_side)
    );

    ptc_div64 u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side_i    (f_side),
        .out_valid (d_valid),
        .quo       (d_quo),
        .side_o    (d_side)
    );

    ptc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (d_valid),
        .quo               (d_quo),
        .side_i            (d_side),
        .press_mid         (press_mid_reg),
        .press_top         (press_top_reg),
        .out_valid         (out_valid),
        .temperature_centi (temperature_centi),
        .pressure_q24_8    (pressure_q24_8),
        .status            (status)
    );

`ifndef SYNTH
    a_bus_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BUS |-> temperature_centi == 24'sd0 && pressure_q24_8 == 32'd0)
        else $error("bus error result carries non-zero fields");

    a_ok_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |->
            pressure_q24_8 >= 32'(PRESS_LOW) && pressure_q24_8 <= 32'(PRESS_HIGH))
        else $error("ok status with pressure out of range");

    a_ok_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |->
            temperature_centi >= 24'(TEMP_LOW) && temperature_centi <= 24'(TEMP_HIGH))
        else $error("ok status with temperature out of range");
`endif

endmodule

/* verif/pressure_temperature_compensation_unit_test.sv */
// Self-checking testbench for the pressure/temperature compensation unit.
`timescale 1ns / 100ps

module pressure_temperature_compensation_unit_test;
    import ptc_pkg::*;

    typedef struct {
        bit       berr;
        bit [7:0] p_msb, p_lsb, p_xlsb, t_msb, t_lsb, t_xlsb;
    } raw_burst_t;

    typedef struct {
        bit [23:0] centi;
        bit [31:0] press;
        bit [1:0]  st;
    } reading_t;

    class compensation_scoreboard;
        bit [47:0] temp_trim;
        bit [63:0] press_low;
        bit [63:0] press_mid;
        bit [15:0] press_top;
        reading_t  awaited[$];
        int        mismatches;

        function void write_trim(bit [1:0] idx, bit [63:0] d);
            case (idx)
                REG_TEMP: temp_trim = d[47:0];
                REG_PLOW: press_low = d;
                REG_PMID: press_mid = d;
                REG_PTOP: press_top = d[15:0];
            endcase
        endfunction

        function longint s16(bit [15:0] v);
            return longint'($signed(v));
        endfunction

        // truncating signed divide; most negative / -1 wraps
        function longint div_trunc(longint n, longint d);
            longint unsigned mn, md, q;
            mn = (n < 0) ? longint'(-n) : n;
            md = (d < 0) ? longint'(-d) : d;
            q  = mn / md;
            return ((n < 0) != (d < 0)) ? longint'(-q) : longint'(q);
        endfunction

        function reading_t compensate(raw_burst_t r);
            reading_t res;
            longint adc_p, adc_t, t1, t2, t3, v1, v2, dt, tfine, centi, ps;
            longint p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p;
            res = '{default: 0};
            if (r.berr)
            begin
                res.st = ST_BUS;
                return res;
            end
            adc_p = longint'({44'd0, r.p_msb, r.p_lsb, r.p_xlsb[7:4]});
            adc_t = longint'({44'd0, r.t_msb, r.t_lsb, r.t_xlsb[7:4]});
            t1 = longint'({48'd0, temp_trim[15:0]});
            t2 = s16(temp_trim[31:16]);
            t3 = s16(temp_trim[47:32]);
            v1 = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
            dt = (adc_t >>> 4) - t1;
            v2 = (((dt * dt) >>> 12) * t3) >>> 14;
            tfine = v1 + v2;
            centi = (tfine * 5 + 128) >>> 8;

            p1 = longint'({48'd0, press_low[15:0]});
            p2 = s16(press_low[31:16]);
            p3 = s16(press_low[47:32]);
            p4 = s16(press_low[63:48]);
            p5 = s16(press_mid[15:0]);
            p6 = s16(press_mid[31:16]);
            p7 = s16(press_mid[47:32]);
            p8 = s16(press_mid[63:48]);
            p9 = s16(press_top);

            a = tfine - TFINE_OFFSET;
            b = a * a * p6;
            b = b + ((a * p5) <<< 17);
            b = b + (p4 <<< 35);
            a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
            a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
            if (a == 0)
                ps = 0;
            else
            begin
                p  = longint'(RAW_FULL) - adc_p;
                p  = div_trunc(((p <<< 31) - b) * longint'(PRESS_SCALE), a);
                a  = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                b  = (p8 * p) >>> 19;
                ps = ((p + a + b) >>> 8) + (p7 <<< 4);
            end

            res.st = (centi < TEMP_LOW || centi > TEMP_HIGH ||
                      ps < PRESS_LOW || ps > PRESS_HIGH) ? ST_RANGE : ST_OK;
            if (centi > 8388607)
                centi = 8388607;
            if (centi < -8388608)
                centi = -8388608;
            res.centi = centi[23:0];
            if (ps < 0)
                res.press = 0;
            else if (ps > 64'sh0_FFFF_FFFF)
                res.press = 32'hFFFF_FFFF;
            else
                res.press = ps[31:0];
            return res;
        endfunction

        function void note_request(raw_burst_t r);
            awaited.push_back(compensate(r));
        endfunction

        function void check_reading(reading_t got);
            reading_t exp_r;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: centi %0h press %0h status %0d",
                             got.centi, got.press, got.st);
                return;
            end
            exp_r = awaited.pop_front();
            if (got.centi != exp_r.centi || got.press != exp_r.press || got.st != exp_r.st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: centi %0h/%0h press %0h/%0h status %0d/%0d (exp/act)",
                             exp_r.centi, got.centi, exp_r.press, got.press,
                             exp_r.st, got.st);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               bus_error;
    logic [7:0]         press_msb, press_lsb, press_xlsb;
    logic [7:0]         temp_msb, temp_lsb, temp_xlsb;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [1:0]         status;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;

    compensation_scoreboard sb = new();
    int burst_left;
    int results_seen;
    int quiet_cycles;

    pressure_temperature_compensation_unit u_dut (.*);

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // typical factory trims
    localparam bit [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
    localparam bit [63:0] TYP_PLOW = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam bit [63:0] TYP_PMID = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam bit [15:0] TYP_PTOP = 16'd6000;

    task automatic send_request(raw_burst_t r);
        int gap;
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        bus_error  = r.berr;
        press_msb  = r.p_msb;
        press_lsb  = r.p_lsb;
        press_xlsb = r.p_xlsb;
        temp_msb   = r.t_msb;
        temp_lsb   = r.t_lsb;
        temp_xlsb  = r.t_xlsb;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(r);
        @(negedge clk);
        burst_left--;
    endtask

    function automatic raw_burst_t pack_raw(bit berr, bit [19:0] p, bit [19:0] t);
        raw_burst_t r;
        r.berr   = berr;
        r.p_msb  = p[19:12];
        r.p_lsb  = p[11:4];
        r.p_xlsb = {p[3:0], 4'($urandom)};
        r.t_msb  = t[19:12];
        r.t_lsb  = t[11:4];
        r.t_xlsb = {t[3:0], 4'($urandom)};
        return r;
    endfunction

    // mostly plausible readings near room conditions, the rest arbitrary bytes
    function automatic raw_burst_t random_raw();
        raw_burst_t r;
        if ($urandom_range(0, 9) < 7)
            return pack_raw($urandom_range(0, 19) == 0,
                            20'($urandom_range(300000, 560000)),
                            20'($urandom_range(430000, 610000)));
        r.berr   = 1'($urandom_range(0, 1));
        r.p_msb  = 8'($urandom);
        r.p_lsb  = 8'($urandom);
        r.p_xlsb = 8'($urandom);
        r.t_msb  = 8'($urandom);
        r.t_lsb  = 8'($urandom);
        r.t_xlsb = 8'($urandom);
        return r;
    endfunction

    task automatic drain();
        in_valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        // pipeline is 86 deep
        repeat (100) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_trims(bit [47:0] t, bit [63:0] pl, bit [63:0] pm, bit [15:0] pt);
        bit [1:0]  idx [4];
        bit [63:0] val [4];
        idx = '{REG_TEMP, REG_PLOW, REG_PMID, REG_PTOP};
        val = '{{16'd0, t}, pl, pm, {48'd0, pt}};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    = 1'b1;
            cfg_index = idx[i];
            cfg_data  = val[i];
            sb.write_trim(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    task automatic run_random(int n);
        repeat (n) send_request(random_raw());
    endtask

    // receiver stall pattern, with one long hold-off to back the pipe up
    initial
    begin
        int mode;
        bit held;
        held      = 0;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 120))
            begin
                @(negedge clk);
                if (!held && results_seen >= 300)
                begin
                    out_stall = 1'b1;
                    repeat (400) @(negedge clk);
                    held = 1;
                end
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 9) < 3);
                    2: out_stall = ($urandom_range(0, 2) == 0);
                    default: out_stall = ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_reading('{temperature_centi, pressure_q24_8, status});
            results_seen <= results_seen + 1;
        end
        if (quiet_cycles > 5000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        raw_burst_t r;
        results_seen = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        bus_error    = 1'b0;
        press_msb    = '0;
        press_lsb    = '0;
        press_xlsb   = '0;
        temp_msb     = '0;
        temp_lsb     = '0;
        temp_xlsb    = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_TEMP;
        cfg_data     = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset trims: zero divisor path throughout
        run_random(20);

        write_trims(TYP_TEMP, TYP_PLOW, TYP_PMID, TYP_PTOP);
        send_request(pack_raw(0, 20'd415148, 20'd519888));
        send_request(pack_raw(1, 20'd415148, 20'd519888));
        send_request(pack_raw(0, 20'h00000, 20'h00000));
        send_request(pack_raw(0, 20'hFFFFF, 20'hFFFFF));
        send_request(pack_raw(0, 20'h00000, 20'hFFFFF));
        send_request(pack_raw(0, 20'hFFFFF, 20'h00000));
        send_request(pack_raw(1, 20'hFFFFF, 20'hFFFFF));
        send_request(pack_raw(0, 20'd415148, 20'd400000));
        send_request(pack_raw(0, 20'd415148, 20'd640000));
        send_request(pack_raw(0, 20'd100000, 20'd519888));
        send_request(pack_raw(0, 20'd700000, 20'd519888));
        send_request(pack_raw(0, 20'd520000, 20'd519888));
        send_request(pack_raw(0, 20'd300000, 20'd519888));
        r = pack_raw(0, 20'd415148, 20'd519888);
        r.p_xlsb[3:0] = 4'hF;
        r.t_xlsb[3:0] = 4'hF;
        send_request(r);
        r.p_xlsb[3:0] = 4'h0;
        r.t_xlsb[3:0] = 4'h0;
        send_request(r);
        run_random(400);

        // trims perturbed around typical
        write_trims(TYP_TEMP ^ 48'($urandom_range(0, 255)),
                    TYP_PLOW ^ 64'($urandom_range(0, 255)),
                    TYP_PMID ^ 64'($urandom_range(0, 255)),
                    TYP_PTOP ^ 16'($urandom_range(0, 255)));
        run_random(250);

        write_trims('1, '1, '1, '1);
        run_random(120);

        write_trims({16'h7FFF, 16'h7FFF, 16'hFFFF},
                    {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                    {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
        run_random(120);

        write_trims({16'h8000, 16'h8000, 16'h0001},
                    {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                    {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
        run_random(120);

        write_trims(48'({$urandom, $urandom}), {$urandom, $urandom},
                    {$urandom, $urandom}, 16'($urandom));
        run_random(120);

        write_trims(TYP_TEMP, TYP_PLOW, TYP_PMID, TYP_PTOP);
        run_random(150);

        drain();
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
